@@ rtl/nts_pkg.sv @@
// Package for the note tracker with sustain.
// Holds the operation codes, field widths and default sizes used by the core and the testbench.
// No dependencies.
package nts_pkg;

    localparam int VoicesDefault = 32;
    localparam int NoteCount     = 128;
    localparam int NoteW         = 7;
    localparam int ToneW         = 32;
    localparam int ActW          = 6;
    localparam int OpW           = 3;
    localparam int MaxResults    = 32;
    localparam int ResCntW       = $clog2(MaxResults + 1);
    localparam int InDataW       = 8;
    localparam int OutDataW      = 72;

    localparam logic [OpW-1:0] OpNoteOn     = 3'd0;
    localparam logic [OpW-1:0] OpNoteOff    = 3'd1;
    localparam logic [OpW-1:0] OpSustainOn  = 3'd2;
    localparam logic [OpW-1:0] OpSustainOff = 3'd3;
    localparam logic [OpW-1:0] OpClear      = 3'd4;

endpackage

@@ rtl/nts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the tone store of the note tracker. No dependencies.
module nts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/note_tracker_with_sustain_core.sv @@
// Top level of the note tracker with sustain: sequencer, note flags and output register.
// Depends on nts_pkg and nts_ram.
//
// Events enter on the s_axis channel (operation in tuser, note number and force
// flag in tdata); results leave on the m_axis channel with tlast on the final
// result of each event and the table-full flag in tuser.
// The table is kept per note number: a used and a held flag for each of the 128
// notes in flip-flops, and the tone ids in a 128-entry RAM. The VOICES parameter
// only bounds how many notes may sound at once.
// Note-on, note-off, sustain-on, clear and unknown events: the accepting cycle reads
// the tone RAM, then S_LOOK decides and loads the output register, waiting while
// the output register still holds a result that the receiver has not taken.
// Sustain-off passes the accepting cycle and a decode state (S_LOOK), walks all 128
// notes one per cycle in S_SCAN, with an S_FETCH state per released note that may
// stall on the receiver, and closes in S_FLUSH. The walk stops after 32 releases.
// The block accepts a new event only when the sequencer is idle; a finished
// result may still wait in the output register. When the receiver stalls, the
// sequencer holds at the point where it must load the next result.
// Reset empties the table, turns sustain off and sets the next tone id to 1.
module note_tracker_with_sustain_core #(
    parameter int VOICES = nts_pkg::VoicesDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Bits from low: note_number[6:0], force_req[7].
    input  logic [nts_pkg::InDataW-1:0]  s_axis_tdata,
    // Bits from low: operation[2:0].
    input  logic [nts_pkg::OpW-1:0]      s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Bits from low: started_tone[31:0], released_tone[63:32], active_notes[69:64].
    output logic [nts_pkg::OutDataW-1:0] m_axis_tdata,
    // Bits from low: table_full[0].
    output logic [0:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);

    localparam int CntW = $clog2(VOICES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [nts_pkg::OpW-1:0]       r_op, n_op;
    logic [nts_pkg::NoteW-1:0]     r_note, n_note;
    logic                          r_force, n_force;
    logic [nts_pkg::NoteCount-1:0] r_used, n_used;
    logic [nts_pkg::NoteCount-1:0] r_held, n_held;
    logic                          r_sustain, n_sustain;
    logic [CntW-1:0]               r_count, n_count;
    logic [nts_pkg::ToneW-1:0]     r_next_tone, n_next_tone;
    logic [nts_pkg::NoteW-1:0]     r_idx, n_idx;
    logic                          r_done, n_done;
    logic [nts_pkg::ResCntW-1:0]   r_k, n_k;
    logic                          r_pend_valid, n_pend_valid;
    logic [nts_pkg::ToneW-1:0]     r_pend_tone, n_pend_tone;
    logic [CntW-1:0]               r_pend_count, n_pend_count;

    logic                          r_out_valid;
    logic [nts_pkg::ToneW-1:0]     r_out_started;
    logic [nts_pkg::ToneW-1:0]     r_out_released;
    logic [nts_pkg::ActW-1:0]      r_out_active;
    logic                          r_out_full;
    logic                          r_out_last;

    logic                          out_free;
    logic                          out_load;
    logic [nts_pkg::ToneW-1:0]     out_started;
    logic [nts_pkg::ToneW-1:0]     out_released;
    logic [CntW-1:0]               out_count;
    logic                          out_full;
    logic                          out_last;
    logic [CntW+nts_pkg::ActW-1:0] out_count_ext;

    logic                          hit;
    logic [nts_pkg::ToneW-1:0]     rel_tone;
    logic [CntW-1:0]               cnt_ar;
    logic [nts_pkg::ToneW-1:0]     tone_inc;

    logic                          ram_wr_en;
    logic                          ram_rd_en;
    logic [nts_pkg::NoteW-1:0]     ram_rd_addr;
    logic [nts_pkg::ToneW-1:0]     ram_rd_data;

    nts_ram #(
        .WIDTH(nts_pkg::ToneW),
        .DEPTH(nts_pkg::NoteCount)
    ) u_tone_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(r_note),
        .i_wr_data(r_next_tone),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign hit           = r_used[r_note];
    assign rel_tone      = hit ? ram_rd_data : '0;
    assign cnt_ar        = r_count - CntW'(hit);
    assign tone_inc      = (r_next_tone == '1) ? nts_pkg::ToneW'(1)
                                               : r_next_tone + nts_pkg::ToneW'(1);
    assign out_count_ext = {{nts_pkg::ActW{1'b0}}, out_count};

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_note       = r_note;
        n_force      = r_force;
        n_used       = r_used;
        n_held       = r_held;
        n_sustain    = r_sustain;
        n_count      = r_count;
        n_next_tone  = r_next_tone;
        n_idx        = r_idx;
        n_done       = r_done;
        n_k          = r_k;
        n_pend_valid = r_pend_valid;
        n_pend_tone  = r_pend_tone;
        n_pend_count = r_pend_count;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_note;
        out_load     = 1'b0;
        out_started  = '0;
        out_released = '0;
        out_count    = r_count;
        out_full     = 1'b0;
        out_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op        = s_axis_tuser;
                    n_note      = s_axis_tdata[nts_pkg::NoteW-1:0];
                    n_force     = s_axis_tdata[nts_pkg::NoteW];
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = s_axis_tdata[nts_pkg::NoteW-1:0];
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_op == nts_pkg::OpSustainOff) begin
                    n_sustain    = 1'b0;
                    n_idx        = '0;
                    n_done       = 1'b0;
                    n_k          = '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_SCAN;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    unique case (r_op)
                        nts_pkg::OpNoteOn: begin
                            out_released   = rel_tone;
                            n_used[r_note] = 1'b0;
                            n_held[r_note] = 1'b0;
                            if (cnt_ar == CntW'(VOICES)) begin
                                out_full  = 1'b1;
                                n_count   = cnt_ar;
                                out_count = cnt_ar;
                            end else begin
                                ram_wr_en      = 1'b1;
                                out_started    = r_next_tone;
                                n_used[r_note] = 1'b1;
                                n_next_tone    = tone_inc;
                                n_count        = cnt_ar + CntW'(1);
                                out_count      = cnt_ar + CntW'(1);
                            end
                        end
                        nts_pkg::OpNoteOff: begin
                            if (!r_sustain || r_force) begin
                                out_released   = rel_tone;
                                n_used[r_note] = 1'b0;
                                n_held[r_note] = 1'b0;
                                n_count        = cnt_ar;
                                out_count      = cnt_ar;
                            end else if (hit) begin
                                n_held[r_note] = 1'b1;
                            end
                        end
                        nts_pkg::OpSustainOn: begin
                            n_sustain = 1'b1;
                        end
                        nts_pkg::OpClear: begin
                            n_used    = '0;
                            n_held    = '0;
                            n_sustain = 1'b0;
                            n_count   = '0;
                            out_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_done || (r_k == nts_pkg::ResCntW'(nts_pkg::MaxResults))) begin
                    n_state = S_FLUSH;
                end else begin
                    if (r_used[r_idx] && r_held[r_idx]) begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = r_idx;
                        n_used[r_idx] = 1'b0;
                        n_held[r_idx] = 1'b0;
                        n_count       = r_count - CntW'(1);
                        n_state       = S_FETCH;
                    end
                    n_idx  = r_idx + nts_pkg::NoteW'(1);
                    n_done = (r_idx == nts_pkg::NoteW'(nts_pkg::NoteCount - 1));
                end
            end
            S_FETCH: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        out_load     = 1'b1;
                        out_released = r_pend_tone;
                        out_count    = r_pend_count;
                        out_last     = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_tone  = ram_rd_data;
                    n_pend_count = r_count;
                    n_k          = r_k + nts_pkg::ResCntW'(1);
                    n_state      = S_SCAN;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_valid) begin
                        out_released = r_pend_tone;
                        out_count    = r_pend_count;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_held       <= '0;
            r_sustain    <= 1'b0;
            r_count      <= '0;
            r_next_tone  <= nts_pkg::ToneW'(1);
            r_done       <= 1'b0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_held       <= n_held;
            r_sustain    <= n_sustain;
            r_count      <= n_count;
            r_next_tone  <= n_next_tone;
            r_done       <= n_done;
            r_k          <= n_k;
            r_pend_valid <= n_pend_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_note       <= n_note;
        r_force      <= n_force;
        r_idx        <= n_idx;
        r_pend_tone  <= n_pend_tone;
        r_pend_count <= n_pend_count;
        if (out_load) begin
            r_out_started  <= out_started;
            r_out_released <= out_released;
            r_out_active   <= out_count_ext[nts_pkg::ActW-1:0];
            r_out_full     <= out_full;
            r_out_last     <= out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_active, r_out_released, r_out_started};
    assign m_axis_tuser  = r_out_full;
    assign m_axis_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(VOICES))
        else $error("active count exceeds the voice limit");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending release left behind after sustain-off");

    a_full_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("tone started on a dropped note-on");

    a_tone_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_tone != '0)
        else $error("tone counter reached zero");

endmodule

@@ sim/note_tracker_with_sustain_core_tb.sv @@
// Self-checking testbench for note_tracker_with_sustain_core.
// A directed sequence and random note and pedal episodes run against a
// per-note tracking model; depends on nts_pkg and the core RTL.
`timescale 1ns / 100ps

module note_tracker_with_sustain_core_tb;

    localparam int ClkPeriod = 4;
    localparam int RandomEvents = 410;
    localparam logic [nts_pkg::OpW-1:0] OpUnknownLo = 3'd5;
    localparam logic [nts_pkg::OpW-1:0] OpUnknownHi = 3'd7;

    typedef struct packed {
        logic [nts_pkg::OpW-1:0]   op;
        logic [nts_pkg::NoteW-1:0] note;
        logic                      force_req;
    } t_midi_event;

    typedef struct packed {
        logic [nts_pkg::ToneW-1:0] started;
        logic [nts_pkg::ToneW-1:0] released;
        logic [nts_pkg::ActW-1:0]  active;
        logic                      full;
        logic                      last;
    } t_tone_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [nts_pkg::InDataW-1:0]  s_axis_tdata = '0;
    logic [nts_pkg::OpW-1:0]      s_axis_tuser = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [nts_pkg::OutDataW-1:0] m_axis_tdata;
    logic [0:0]                   m_axis_tuser;
    logic                         m_axis_tlast;

    note_tracker_with_sustain_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_midi_event  pending_events[$];
    t_tone_result tone_results_q[$];
    int           recent_notes[$];
    t_midi_event  cur_event;
    int           events_accepted = 0;
    int           n_events = 0;
    int           err_cnt = 0;
    int           gap_cnt = 0;
    int           burst_cnt = 0;
    int           hold_cnt = 0;
    bit           hold_done = 1'b0;
    int           rx_phase = 0;
    int           rx_mode = 0;
    logic [7:0]   rx_pat = 8'hff;

    // Per-note view of the voice table.
    bit                        note_used[nts_pkg::NoteCount];
    bit                        note_held[nts_pkg::NoteCount];
    logic [nts_pkg::ToneW-1:0] note_tone[nts_pkg::NoteCount];
    int                        active_cnt = 0;
    bit                        sustain_flag = 1'b0;
    logic [nts_pkg::ToneW-1:0] next_id = 1;

    initial begin
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    function automatic logic [nts_pkg::ToneW-1:0] drop_note(int n);
        if (!note_used[n]) begin
            return '0;
        end
        note_used[n] = 1'b0;
        note_held[n] = 1'b0;
        active_cnt--;
        return note_tone[n];
    endfunction

    task automatic track_event(t_midi_event ev);
        t_tone_result r;
        logic [nts_pkg::ToneW-1:0] rel;
        int k;
        int n;
        n = int'(ev.note);
        r = '0;
        r.last = 1'b1;
        unique case (ev.op)
            nts_pkg::OpNoteOn: begin
                r.released = drop_note(n);
                if (active_cnt >= nts_pkg::VoicesDefault) begin
                    r.full = 1'b1;
                end else begin
                    r.started = next_id;
                    next_id = next_id + 1;
                    if (next_id == 0) begin
                        next_id = 1;
                    end
                    note_used[n] = 1'b1;
                    note_held[n] = 1'b0;
                    note_tone[n] = r.started;
                    active_cnt++;
                end
            end
            nts_pkg::OpNoteOff: begin
                if (!sustain_flag || ev.force_req) begin
                    r.released = drop_note(n);
                end else if (note_used[n]) begin
                    note_held[n] = 1'b1;
                end
            end
            nts_pkg::OpSustainOn: begin
                sustain_flag = 1'b1;
            end
            nts_pkg::OpSustainOff: begin
                sustain_flag = 1'b0;
                k = 0;
                for (int i = 0; i < nts_pkg::NoteCount && k < nts_pkg::MaxResults; i++) begin
                    if (note_used[i] && note_held[i]) begin
                        if (k > 0) begin
                            tone_results_q = {tone_results_q, r};
                        end
                        rel = drop_note(i);
                        r = '0;
                        r.released = rel;
                        r.active = nts_pkg::ActW'(active_cnt);
                        k++;
                    end
                end
                r.last = 1'b1;
            end
            nts_pkg::OpClear: begin
                for (int i = 0; i < nts_pkg::NoteCount; i++) begin
                    note_used[i] = 1'b0;
                    note_held[i] = 1'b0;
                end
                active_cnt = 0;
                sustain_flag = 1'b0;
            end
            default: begin
            end
        endcase
        r.active = nts_pkg::ActW'(active_cnt);
        tone_results_q = {tone_results_q, r};
    endtask

    function automatic void add_event(logic [nts_pkg::OpW-1:0] op, int note, bit force_req);
        t_midi_event ev;
        ev.op = op;
        ev.note = nts_pkg::NoteW'(note);
        ev.force_req = force_req;
        pending_events = {pending_events, ev};
        if (op == nts_pkg::OpNoteOn) begin
            recent_notes = {recent_notes, note};
            if (recent_notes.size() > 40) begin
                void'(recent_notes.pop_front());
            end
        end
    endfunction

    function automatic int pick_note();
        if (recent_notes.size() != 0 && $urandom_range(0, 1) == 1) begin
            return recent_notes[$urandom_range(0, recent_notes.size() - 1)];
        end
        return int'($urandom_range(0, nts_pkg::NoteCount - 1));
    endfunction

    function automatic void add_noise_event();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 45) begin
            add_event(nts_pkg::OpNoteOn, pick_note(), 1'($urandom_range(0, 1)));
        end else if (r < 75) begin
            add_event(nts_pkg::OpNoteOff, pick_note(), $urandom_range(0, 3) == 0);
        end else if (r < 83) begin
            add_event(nts_pkg::OpSustainOn, pick_note(), 1'($urandom_range(0, 1)));
        end else if (r < 91) begin
            add_event(nts_pkg::OpSustainOff, pick_note(), 1'($urandom_range(0, 1)));
        end else if (r < 95) begin
            add_event(nts_pkg::OpClear, pick_note(), 1'($urandom_range(0, 1)));
        end else begin
            add_event(nts_pkg::OpW'($urandom_range(OpUnknownLo, OpUnknownHi)), pick_note(),
                      1'($urandom_range(0, 1)));
        end
    endfunction

    function automatic void add_pedal_episode();
        int held[$];
        int cnt;
        if ($urandom_range(0, 1) == 1) begin
            add_event(nts_pkg::OpClear, int'($urandom_range(0, nts_pkg::NoteCount - 1)), 1'b0);
        end
        add_event(nts_pkg::OpSustainOn, int'($urandom_range(0, nts_pkg::NoteCount - 1)),
                  1'($urandom_range(0, 1)));
        cnt = int'($urandom_range(4, 40));
        for (int i = 0; i < cnt; i++) begin
            held = {held, int'($urandom_range(0, nts_pkg::NoteCount - 1))};
            add_event(nts_pkg::OpNoteOn, held[$], 1'($urandom_range(0, 1)));
        end
        foreach (held[i]) begin
            add_event(nts_pkg::OpNoteOff, held[i], $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 7) == 0) begin
                add_noise_event();
            end
        end
        add_event(nts_pkg::OpSustainOff, int'($urandom_range(0, nts_pkg::NoteCount - 1)),
                  1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) begin
            add_event(nts_pkg::OpSustainOff, int'($urandom_range(0, nts_pkg::NoteCount - 1)),
                      1'b0);
        end
    endfunction

    task automatic check_field(string name, logic [nts_pkg::ToneW-1:0] want,
                               logic [nts_pkg::ToneW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Sender: offers events in bursts with idle gaps and predicts each accepted beat.
    always @(posedge i_clk) begin : drv
        t_midi_event ev;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_event(cur_event);
                events_accepted <= events_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_cnt != 0) begin
                    gap_cnt <= gap_cnt - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    ev = pending_events.pop_front();
                    cur_event <= ev;
                    s_axis_tdata <= {ev.force_req, ev.note};
                    s_axis_tuser <= ev.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_cnt <= 1) begin
                        burst_cnt <= int'($urandom_range(1, 16));
                        gap_cnt <= ($urandom_range(0, 3) == 0) ? 0
                                                               : int'($urandom_range(1, 8));
                    end else begin
                        burst_cnt <= burst_cnt - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: picks a new stall pattern at the start of each rx_phase period, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && events_accepted >= 120) begin
            hold_done <= 1'b1;
            hold_cnt <= 600;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_mode <= int'($urandom_range(0, 3));
                rx_pat <= 8'($urandom);
            end
            rx_phase <= (rx_phase + 1) % 48;
            unique case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= rx_pat[rx_phase % 8];
            endcase
        end
    end

    always @(posedge i_clk) begin : mon
        t_tone_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tone_results_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, m_axis_tdata);
                err_cnt++;
            end else begin
                want = tone_results_q.pop_front();
                check_field("started_tone", want.started, m_axis_tdata[31:0]);
                check_field("released_tone", want.released, m_axis_tdata[63:32]);
                check_field("active_notes", nts_pkg::ToneW'(want.active),
                            nts_pkg::ToneW'(m_axis_tdata[69:64]));
                check_field("table_full", nts_pkg::ToneW'(want.full),
                            nts_pkg::ToneW'(m_axis_tuser[0]));
                check_field("last_result", nts_pkg::ToneW'(want.last),
                            nts_pkg::ToneW'(m_axis_tlast));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < nts_pkg::NoteCount; i++) begin
            note_used[i] = 1'b0;
            note_held[i] = 1'b0;
            note_tone[i] = '0;
        end
        // Directed: note extremes, retrigger, absent notes, held and forced
        // note-off, empty pedal release, unknown operations and clear.
        add_event(nts_pkg::OpNoteOn, 0, 1'b0);
        add_event(nts_pkg::OpNoteOn, 127, 1'b1);
        add_event(nts_pkg::OpNoteOn, 0, 1'b0);
        add_event(nts_pkg::OpNoteOff, 64, 1'b0);
        add_event(nts_pkg::OpNoteOff, 127, 1'b0);
        add_event(nts_pkg::OpSustainOff, 0, 1'b0);
        add_event(nts_pkg::OpSustainOn, 0, 1'b0);
        add_event(nts_pkg::OpNoteOn, 85, 1'b0);
        add_event(nts_pkg::OpNoteOn, 42, 1'b0);
        add_event(nts_pkg::OpNoteOff, 85, 1'b0);
        add_event(nts_pkg::OpNoteOff, 0, 1'b1);
        add_event(nts_pkg::OpNoteOff, 42, 1'b0);
        add_event(nts_pkg::OpNoteOff, 100, 1'b0);
        add_event(nts_pkg::OpNoteOn, 85, 1'b0);
        add_event(nts_pkg::OpSustainOff, 127, 1'b1);
        add_event(OpUnknownLo, 0, 1'b0);
        add_event(OpUnknownLo + 3'd1, 127, 1'b1);
        add_event(OpUnknownHi, 85, 1'b0);
        add_event(nts_pkg::OpNoteOff, 85, 1'b0);
        add_event(nts_pkg::OpSustainOn, 0, 1'b0);
        add_event(nts_pkg::OpNoteOn, 10, 1'b0);
        add_event(nts_pkg::OpClear, 0, 1'b0);
        add_event(nts_pkg::OpNoteOff, 10, 1'b0);
        add_event(nts_pkg::OpSustainOff, 0, 1'b0);
        n_events = RandomEvents;
        while (pending_events.size() < n_events) begin
            if ($urandom_range(0, 2) == 0) begin
                for (int i = int'($urandom_range(10, 30)); i > 0; i--) begin
                    add_noise_event();
                end
            end else begin
                add_pedal_episode();
            end
        end
        n_events = pending_events.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (events_accepted != n_events) @(posedge i_clk);
        while (tone_results_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/nts_pkg.sv
rtl/nts_ram.sv
rtl/note_tracker_with_sustain_core.sv
sim/note_tracker_with_sustain_core_tb.sv
